@@ design/uam_pkg.sv @@
// Package for the undirected adjacency matrix block.
// Holds the mode codes and the command and status structs between the
// controller and the datapath. Depends on nothing.
package uam_pkg;

    // Operation codes of the mode field; the unused code acts as a query.
    localparam logic [1:0] MODE_QUERY  = 2'd0;
    localparam logic [1:0] MODE_INSERT = 2'd1;
    localparam logic [1:0] MODE_REMOVE = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;    // latch the input word and read the first row
        logic step_a;    // update the first row and read the second row
        logic finish_b;  // update the second row and load the result word
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;  // the result register can take a new word this cycle
    } t_status;

endpackage

@@ design/uam_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Used for the rows of the adjacency matrix. Depends on nothing.
module uam_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/uam_ctrl.sv @@
// Controller state machine of the undirected adjacency matrix block.
// Steps each word through the first-row and second-row updates.
// Depends on uam_pkg.
module uam_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  uam_pkg::t_status i_status,
    output uam_pkg::t_cmd    o_cmd
);
    import uam_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ROW_A,
        S_ROW_B
    } t_state;

    t_state r_state;
    t_state n_state;

    // Commands follow directly from the state and the handshakes.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.accept = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_ROW_A;
                end
            end
            S_ROW_A: begin
                o_cmd.step_a = 1'b1;
                n_state      = S_ROW_B;
            end
            S_ROW_B: begin
                // Hold here until the result register is free.
                o_cmd.finish_b = i_status.out_free;
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // An accepted word always moves on to the first-row update.
    a_accept_to_row_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |=> (r_state == S_ROW_A))
        else $error("accepted word did not reach the first-row update");

    // The first-row update is always followed by the second-row update.
    a_row_a_to_row_b: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROW_A) |=> (r_state == S_ROW_B))
        else $error("second-row update skipped");

    // A result is only loaded when the output register can take it.
    a_finish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish_b |-> i_status.out_free)
        else $error("result loaded into an occupied output register");

endmodule

@@ design/uam_dpath.sv @@
// Datapath of the undirected adjacency matrix block: row RAM, row valid bits,
// edge counter, vertex count register and the result register.
// Depends on uam_pkg and uam_ram.
module uam_dpath #(
    parameter int MAX_VERTICES = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  uam_pkg::t_cmd    i_cmd,
    output uam_pkg::t_status o_status,
    input  logic             i_cfg_we,
    input  logic [4:0]       i_cfg_data,
    input  logic [1:0]       i_mode,
    input  logic [3:0]       i_first_vertex,
    input  logic [3:0]       i_second_vertex,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic             o_pair_valid,
    output logic             o_edge_was_present,
    output logic             o_vertex_valid,
    output logic [3:0]       o_vertex_degree,
    output logic             o_has_neighbour,
    output logic [6:0]       o_edge_total
);
    import uam_pkg::*;

    localparam int AW  = $clog2(MAX_VERTICES);
    localparam int PW  = $clog2(MAX_VERTICES + 1);
    localparam int CW  = $clog2(MAX_VERTICES * (MAX_VERTICES - 1) / 2 + 1);
    localparam int EW  = (CW > 7) ? CW : 7;
    localparam int DXW = (PW > 4) ? PW : 4;
    localparam int RST_VC = (16 > MAX_VERTICES) ? MAX_VERTICES : 16;

    // Item and control registers.
    logic [1:0]              r_mode;
    logic [3:0]              r_a;
    logic [3:0]              r_b;
    logic                    r_a_ok;
    logic                    r_pair_ok;
    logic                    r_was;
    logic                    r_chg;
    logic [PW-1:0]           r_deg;
    logic [MAX_VERTICES-1:0] r_row_ok;
    logic [CW-1:0]           r_edge_cnt;
    logic [4:0]              r_vcount;

    // Result register.
    logic                    r_out_valid;
    logic                    r_out_pair;
    logic                    r_out_was;
    logic                    r_out_vok;
    logic [3:0]              r_out_deg;
    logic                    r_out_nbr;
    logic [6:0]              r_out_total;

    logic [7:0]              in_a_wide;
    logic [7:0]              a_wide;
    logic [7:0]              b_wide;
    logic [AW-1:0]           in_a_idx;
    logic [AW-1:0]           a_idx;
    logic [AW-1:0]           b_idx;
    logic                    in_a_ok;
    logic                    in_b_ok;
    logic [MAX_VERTICES-1:0] rdata;
    logic [MAX_VERTICES-1:0] row_a;
    logic [MAX_VERTICES-1:0] row_b;
    logic [MAX_VERTICES-1:0] bit_a;
    logic [MAX_VERTICES-1:0] bit_b;
    logic [MAX_VERTICES-1:0] new_row_a;
    logic                    was;
    logic                    chg;
    logic                    ins;
    logic [PW-1:0]           deg_cnt;
    logic                    we;
    logic [AW-1:0]           waddr;
    logic [MAX_VERTICES-1:0] wdata;
    logic [AW-1:0]           raddr;
    logic [6:0]              cfg_wide;
    logic [6:0]              max_wide;
    logic [4:0]              cfg_sat;
    logic [EW-1:0]           cnt_ext;
    logic [6:0]              total_sat;
    logic [DXW-1:0]          deg_ext;

    // Vertex numbers narrowed or widened to row addresses.
    assign in_a_wide = 8'(i_first_vertex);
    assign a_wide    = 8'(r_a);
    assign b_wide    = 8'(r_b);
    assign in_a_idx  = in_a_wide[AW-1:0];
    assign a_idx     = a_wide[AW-1:0];
    assign b_idx     = b_wide[AW-1:0];

    assign in_a_ok = {1'b0, i_first_vertex} < r_vcount;
    assign in_b_ok = {1'b0, i_second_vertex} < r_vcount;

    // A row never written since the last clear reads as empty.
    assign row_a = r_row_ok[a_idx] ? rdata : '0;
    assign row_b = r_row_ok[b_idx] ? rdata : '0;
    assign bit_a = {{(MAX_VERTICES - 1){1'b0}}, 1'b1} << a_idx;
    assign bit_b = {{(MAX_VERTICES - 1){1'b0}}, 1'b1} << b_idx;

    // Edge lookup and decision on the first row.
    assign was       = r_pair_ok & row_a[b_idx];
    assign ins       = (r_mode == MODE_INSERT) & ~was;
    assign chg       = r_pair_ok & (ins | ((r_mode == MODE_REMOVE) & was));
    assign new_row_a = chg ? (row_a ^ bit_b) : row_a;

    // Population count of the updated first row.
    always_comb begin
        deg_cnt = '0;
        for (int k = 0; k < MAX_VERTICES; k++) begin
            deg_cnt = deg_cnt + PW'(new_row_a[k]);
        end
    end

    // RAM port selection: first row is written during its update, the
    // second row when the result is loaded.
    assign we    = (i_cmd.step_a & chg) | (i_cmd.finish_b & r_chg);
    assign waddr = i_cmd.step_a ? a_idx : b_idx;
    assign wdata = i_cmd.step_a ? new_row_a : (row_b ^ bit_a);
    assign raddr = i_cmd.accept ? in_a_idx : b_idx;

    uam_ram #(
        .WIDTH (MAX_VERTICES),
        .DEPTH (MAX_VERTICES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // Configuration value saturated to the matrix size.
    assign cfg_wide = 7'(i_cfg_data);
    assign max_wide = 7'(MAX_VERTICES);
    assign cfg_sat  = (cfg_wide > max_wide) ? max_wide[4:0] : i_cfg_data;

    // Saturated views of the counters for the result word.
    assign cnt_ext   = EW'(r_edge_cnt);
    assign total_sat = (cnt_ext > EW'(127)) ? 7'd127 : cnt_ext[6:0];
    assign deg_ext   = DXW'(r_deg);

    // Item registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_mode    <= i_mode;
            r_a       <= i_first_vertex;
            r_b       <= i_second_vertex;
            r_a_ok    <= in_a_ok;
            r_pair_ok <= in_a_ok & in_b_ok & (i_first_vertex != i_second_vertex);
        end
        if (i_cmd.step_a) begin
            r_was <= was;
            r_deg <= r_a_ok ? deg_cnt : '0;
        end
    end

    // Control state: change flag, valid bits, edge counter, vertex count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chg      <= 1'b0;
            r_row_ok   <= '0;
            r_edge_cnt <= '0;
            r_vcount   <= 5'(RST_VC);
        end else if (i_cfg_we) begin
            r_chg      <= 1'b0;
            r_row_ok   <= '0;
            r_edge_cnt <= '0;
            r_vcount   <= cfg_sat;
        end else begin
            if (i_cmd.step_a) begin
                r_chg <= chg;
                if (chg) begin
                    r_row_ok[a_idx] <= 1'b1;
                    r_edge_cnt      <= ins ? (r_edge_cnt + 1'b1) : (r_edge_cnt - 1'b1);
                end
            end
            if (i_cmd.finish_b && r_chg) begin
                r_row_ok[b_idx] <= 1'b1;
            end
        end
    end

    // Output register: filled when a word finishes, emptied when taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish_b) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish_b) begin
            r_out_pair  <= r_pair_ok;
            r_out_was   <= r_was;
            r_out_vok   <= r_a_ok;
            r_out_deg   <= (deg_ext > DXW'(15)) ? 4'd15 : deg_ext[3:0];
            r_out_nbr   <= (r_deg != '0);
            r_out_total <= total_sat;
        end
    end

    assign o_status.out_free  = ~r_out_valid | i_out_ready;
    assign o_out_valid        = r_out_valid;
    assign o_pair_valid       = r_out_pair;
    assign o_edge_was_present = r_out_was;
    assign o_vertex_valid     = r_out_vok;
    assign o_vertex_degree    = r_out_deg;
    assign o_has_neighbour    = r_out_nbr;
    assign o_edge_total       = r_out_total;

    // The matrix is only ever written for a valid pair.
    a_write_valid_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        we |-> r_pair_ok)
        else $error("matrix written for an invalid pair");

    // The edge counter moves by at most one per word.
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.step_a && !i_cfg_we) |=>
            (r_edge_cnt == $past(r_edge_cnt)) ||
            (r_edge_cnt == CW'($past(r_edge_cnt) + 1'b1)) ||
            (r_edge_cnt == CW'($past(r_edge_cnt) - 1'b1)))
        else $error("edge counter jumped");

    // A pending result leaves only when the consumer has taken it.
    a_out_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_out_valid) |-> $past(i_out_ready))
        else $error("result word dropped");

endmodule

@@ design/undirected_adjacency_matrix.sv @@
// Top level of the undirected adjacency matrix block.
// Joins the controller (uam_ctrl) and the datapath (uam_dpath); uses uam_pkg.
//
//   Channel   Handshake                   Payload
//   input     i_in_valid / o_in_ready     i_mode, i_first_vertex, i_second_vertex
//   result    o_out_valid / i_out_ready   o_pair_valid, o_edge_was_present,
//                                         o_vertex_valid, o_vertex_degree,
//                                         o_has_neighbour, o_edge_total
//   config    i_cfg_we                    i_cfg_data (vertex count)
//
// Each word goes through three steps: accept with a read of the first row, update
// of the first row with a read of the second, then update of the second row.
// The single write port of the row RAM sets this sequence of steps.
// Reset and a vertex-count write clear the per-row valid bits all at once;
// there is no clearing pass. A stalled result holds the third step, and the
// next word is taken once the result has moved into the output register.
module undirected_adjacency_matrix #(
    parameter int MAX_VERTICES = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [4:0] i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_mode,
    input  logic [3:0] i_first_vertex,
    input  logic [3:0] i_second_vertex,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_pair_valid,
    output logic       o_edge_was_present,
    output logic       o_vertex_valid,
    output logic [3:0] o_vertex_degree,
    output logic       o_has_neighbour,
    output logic [6:0] o_edge_total
);
    import uam_pkg::*;

    t_cmd    cmd;
    t_status status;

    // Controller.
    uam_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // Datapath.
    uam_dpath #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_dpath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_status           (status),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_data         (i_cfg_data),
        .i_mode             (i_mode),
        .i_first_vertex     (i_first_vertex),
        .i_second_vertex    (i_second_vertex),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_pair_valid       (o_pair_valid),
        .o_edge_was_present (o_edge_was_present),
        .o_vertex_valid     (o_vertex_valid),
        .o_vertex_degree    (o_vertex_degree),
        .o_has_neighbour    (o_has_neighbour),
        .o_edge_total       (o_edge_total)
    );

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the undirected adjacency matrix block.
// Depends on uam_pkg and undirected_adjacency_matrix from the design folder.
module testbench;
    import uam_pkg::*;

    localparam int          GRAPH_VERTICES = 16;
    localparam logic [1:0]  MODE_SPARE     = 2'd3;
    localparam int          HOLD_CYCLES    = 300;
    localparam int          WATCHDOG_LIMIT = 4000;
    localparam int          SETTLE_CYCLES  = 8;

    typedef struct packed {
        logic       pair_valid;
        logic       edge_was_present;
        logic       vertex_valid;
        logic [3:0] vertex_degree;
        logic       has_neighbour;
        logic [6:0] edge_total;
    } t_graph_result;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [4:0] i_cfg_data;
    logic       i_in_valid;
    logic       o_in_ready;
    logic [1:0] i_mode;
    logic [3:0] i_first_vertex;
    logic [3:0] i_second_vertex;
    logic       o_out_valid;
    logic       i_out_ready;
    logic       o_pair_valid;
    logic       o_edge_was_present;
    logic       o_vertex_valid;
    logic [3:0] o_vertex_degree;
    logic       o_has_neighbour;
    logic [6:0] o_edge_total;

    // Predicted graph state, kept in step with the block.
    logic [GRAPH_VERTICES-1:0] adj_rows [GRAPH_VERTICES];
    int unsigned               edge_count;
    int unsigned               active_vertices;
    t_graph_result             pending_results [$];

    int unsigned error_count    = 0;
    int unsigned stall_cycles   = 0;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned hold_left      = 0;
    bit          hold_req       = 1'b0;

    undirected_adjacency_matrix #(
        .MAX_VERTICES(GRAPH_VERTICES)
    ) u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_mode             (i_mode),
        .i_first_vertex     (i_first_vertex),
        .i_second_vertex    (i_second_vertex),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_pair_valid       (o_pair_valid),
        .o_edge_was_present (o_edge_was_present),
        .o_vertex_valid     (o_vertex_valid),
        .o_vertex_degree    (o_vertex_degree),
        .o_has_neighbour    (o_has_neighbour),
        .o_edge_total       (o_edge_total)
    );

    // Free-running clock with a 20 ns period.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Clears the predicted matrix and edge count.
    function automatic void clear_graph();
        for (int r = 0; r < GRAPH_VERTICES; r++) begin
            adj_rows[r] = '0;
        end
        edge_count = 0;
    endfunction

    // Applies one operation to the predicted graph and returns the word it should produce.
    function automatic t_graph_result apply_graph_op(logic [1:0] mode, logic [3:0] a,
                                                     logic [3:0] b);
        t_graph_result res;
        logic          a_ok;
        logic          b_ok;
        logic          pair_ok;
        int unsigned   degree;
        res     = '0;
        a_ok    = a < active_vertices;
        b_ok    = b < active_vertices;
        pair_ok = a_ok && b_ok && (a != b);
        degree  = 0;
        if (pair_ok) begin
            res.edge_was_present = adj_rows[a][b];
            if (mode == MODE_INSERT && !adj_rows[a][b]) begin
                adj_rows[a][b] = 1'b1;
                adj_rows[b][a] = 1'b1;
                edge_count++;
            end else if (mode == MODE_REMOVE && adj_rows[a][b]) begin
                adj_rows[a][b] = 1'b0;
                adj_rows[b][a] = 1'b0;
                edge_count--;
            end
        end
        if (a_ok) begin
            degree = $countones(adj_rows[a]);
        end
        res.pair_valid    = pair_ok;
        res.vertex_valid  = a_ok;
        res.vertex_degree = (degree > 15) ? 4'd15 : degree[3:0];
        res.has_neighbour = degree != 0;
        res.edge_total    = (edge_count > 127) ? 7'd127 : edge_count[6:0];
        return res;
    endfunction

    function automatic void check_field(string name, int unsigned expv, int unsigned actv);
        if (expv != actv) begin
            $error("%s mismatch: expected %0d, actual %0d", name, expv, actv);
            error_count++;
        end
    endfunction

    // Sampling at the rising edge: check results, track config writes, predict new words.
    always @(posedge i_clk) begin
        t_graph_result want;
        if (!i_rst_n) begin
            clear_graph();
            active_vertices = GRAPH_VERTICES;
            pending_results.delete();
            stall_cycles++;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (pending_results.size() == 0) begin
                    $error("Result word arrived with no prediction waiting");
                    error_count++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("pair_valid", 32'(want.pair_valid), 32'(o_pair_valid));
                    check_field("edge_was_present", 32'(want.edge_was_present),
                                32'(o_edge_was_present));
                    check_field("vertex_valid", 32'(want.vertex_valid),
                                32'(o_vertex_valid));
                    check_field("vertex_degree", 32'(want.vertex_degree),
                                32'(o_vertex_degree));
                    check_field("has_neighbour", 32'(want.has_neighbour),
                                32'(o_has_neighbour));
                    check_field("edge_total", 32'(want.edge_total), 32'(o_edge_total));
                end
            end
            if (i_cfg_we) begin
                active_vertices = (i_cfg_data > GRAPH_VERTICES) ? GRAPH_VERTICES : i_cfg_data;
                clear_graph();
            end
            if (i_in_valid && o_in_ready) begin
                pending_results.push_back(apply_graph_op(i_mode, i_first_vertex,
                                                         i_second_vertex));
            end
            if ((o_out_valid && i_out_ready) || (i_in_valid && o_in_ready) || i_cfg_we) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
        end
    end

    // Result side: random stalls, plus one long hold-off when requested.
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Watchdog: gives up when nothing has moved for too long.
    initial begin
        wait (stall_cycles >= WATCHDOG_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Offers one word, after a random idle gap, and holds it until it is taken.
    task automatic send_word(logic [1:0] mode, logic [3:0] a, logic [3:0] b);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_mode          <= mode;
        i_first_vertex  <= a;
        i_second_vertex <= b;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    // Stops offering and waits until every predicted word has come back.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_vertex_count(logic [4:0] value);
        drain_results();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        @(negedge i_clk);
    endtask

    // Hand-picked operations on the reset configuration of sixteen vertices.
    task automatic test_after_reset();
        send_word(MODE_QUERY,  4'd0,  4'd15);
        send_word(MODE_INSERT, 4'd0,  4'd15);
        send_word(MODE_INSERT, 4'd15, 4'd0);
        send_word(MODE_INSERT, 4'd15, 4'd14);
        send_word(MODE_QUERY,  4'd15, 4'd15);
        send_word(MODE_SPARE,  4'd14, 4'd15);
        send_word(MODE_INSERT, 4'd7,  4'd7);
        send_word(MODE_REMOVE, 4'd0,  4'd15);
        send_word(MODE_REMOVE, 4'd0,  4'd15);
        send_word(MODE_REMOVE, 4'd15, 4'd14);
        drain_results();
    endtask

    // Vertex count extremes: zero, saturation above the maximum, one and two.
    task automatic test_vertex_count();
        write_vertex_count(5'd0);
        send_word(MODE_INSERT, 4'd0, 4'd1);
        send_word(MODE_QUERY,  4'd0, 4'd0);
        write_vertex_count(5'd31);
        send_word(MODE_INSERT, 4'd15, 4'd0);
        send_word(MODE_QUERY,  4'd0,  4'd15);
        write_vertex_count(5'd1);
        send_word(MODE_INSERT, 4'd0, 4'd1);
        send_word(MODE_QUERY,  4'd0, 4'd5);
        write_vertex_count(5'd17);
        send_word(MODE_QUERY,  4'd15, 4'd0);
        write_vertex_count(5'd2);
        send_word(MODE_INSERT, 4'd1, 4'd0);
        send_word(MODE_INSERT, 4'd0, 4'd2);
        send_word(MODE_REMOVE, 4'd0, 4'd1);
        drain_results();
    endtask

    // Builds the complete graph in random order, then takes it apart again.
    task automatic test_full_graph();
        logic [7:0] pairs [$];
        logic [7:0] tmp;
        int unsigned j;
        send_idle_pct  = 27;
        recv_stall_pct = 27;
        write_vertex_count(5'd16);
        for (int a = 0; a < GRAPH_VERTICES; a++) begin
            for (int b = a + 1; b < GRAPH_VERTICES; b++) begin
                pairs.push_back({a[3:0], b[3:0]});
            end
        end
        for (int pass = 0; pass < 2; pass++) begin
            for (int i = pairs.size() - 1; i > 0; i--) begin
                j        = $urandom_range(0, i);
                tmp      = pairs[i];
                pairs[i] = pairs[j];
                pairs[j] = tmp;
            end
            foreach (pairs[i]) begin
                if ($urandom_range(0, 1)) begin
                    send_word(pass == 0 ? MODE_INSERT : MODE_REMOVE, pairs[i][7:4], pairs[i][3:0]);
                end else begin
                    send_word(pass == 0 ? MODE_INSERT : MODE_REMOVE, pairs[i][3:0], pairs[i][7:4]);
                end
            end
        end
        drain_results();
    endtask

    // Random operations under one idling setting and one vertex count.
    task automatic run_random_phase(int unsigned idle_send, int unsigned idle_recv,
                                    logic [4:0] vcount, int unsigned count);
        logic [1:0]  mode;
        logic [3:0]  a;
        logic [3:0]  b;
        int unsigned span;
        int unsigned pick;
        send_idle_pct  = idle_send;
        recv_stall_pct = idle_recv;
        write_vertex_count(vcount);
        span = (vcount > GRAPH_VERTICES) ? GRAPH_VERTICES : vcount;
        repeat (count) begin
            pick = $urandom_range(0, 99);
            mode = (pick < 45) ? MODE_INSERT : (pick < 75) ? MODE_REMOVE :
                   (pick < 95) ? MODE_QUERY : MODE_SPARE;
            if (span != 0 && $urandom_range(0, 99) < 85) begin
                a = 4'($urandom_range(0, span - 1));
                b = 4'($urandom_range(0, span - 1));
            end else begin
                a = 4'($urandom_range(0, 15));
                b = 4'($urandom_range(0, 15));
            end
            send_word(mode, a, b);
        end
        drain_results();
    endtask

    task automatic test_random();
        run_random_phase(0,  0,  5'd16, 300);
        run_random_phase(77, 0,  5'd16, 300);
        run_random_phase(0,  77, 5'd6,  280);
        run_random_phase(27, 27, 5'd16, 300);
        run_random_phase(27, 27, 5'd3,  100);
    endtask

    // The result side holds off for a long stretch while words keep coming.
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        write_vertex_count(5'd16);
        @(posedge i_clk);
        hold_req = 1'b1;
        @(negedge i_clk);
        repeat (12) begin
            send_word(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                      4'($urandom_range(0, 15)));
        end
        drain_results();
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_data      = 5'd0;
        i_in_valid      = 1'b0;
        i_mode          = MODE_QUERY;
        i_first_vertex  = 4'd0;
        i_second_vertex = 4'd0;
        i_out_ready     = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_after_reset();
        test_vertex_count();
        test_full_graph();
        test_random();
        test_backpressure();

        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
